// ===== design/eucm_pkg.sv =====
`default_nettype none
package eucm_pkg;

   // square root pipe geometry
   localparam int SQRT_STAGES = 26;
   localparam int S_W         = 2 * SQRT_STAGES;
   localparam int ROOT_W      = SQRT_STAGES;
   localparam int SREM_W      = ROOT_W + 3;

   // divider pipe geometry
   localparam int DIV_STAGES  = 29;
   localparam int NUM_W       = 60;
   localparam int DEN_W       = 44;
   localparam int REM_W       = DEN_W + 1;

   // register indexes
   localparam logic [2:0] REG_FOCAL_U = 3'd0;
   localparam logic [2:0] REG_FOCAL_V = 3'd1;
   localparam logic [2:0] REG_CENTER_U = 3'd2;
   localparam logic [2:0] REG_CENTER_V = 3'd3;
   localparam logic [2:0] REG_SHAPE_ALPHA = 3'd4;
   localparam logic [2:0] REG_SHAPE_BETA = 3'd5;

   // output range
   localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
   localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

   // ray components riding along the square root pipe
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } ray_type;

   // per-axis status riding along the divider pipe
   typedef struct packed {
      logic neg;
      logic ovf;
      logic ok;
   } div_tag_type;

endpackage
`default_nettype wire

// ===== design/eucm_sqrt_pipe.sv =====
`default_nettype none
module eucm_sqrt_pipe import eucm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_vld,
   input  wire logic [S_W-1:0]    in_s,
   input  wire ray_type           in_tag,
   output logic                   out_vld,
   output logic [ROOT_W-1:0]      out_root,
   output ray_type                out_tag
);

   logic                vld_ff  [SQRT_STAGES];
   logic [S_W-1:0]      s_ff    [SQRT_STAGES];
   logic [SREM_W-1:0]   rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_ff [SQRT_STAGES];
   ray_type             tag_ff  [SQRT_STAGES];

   logic [SREM_W-1:0]   rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_in [SQRT_STAGES];

   // one result bit per stage, restoring digit recurrence
   always_comb begin
      logic [S_W-1:0]    s_cur;
      logic [SREM_W-1:0] rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [SREM_W-1:0] rem_sh;
      logic [SREM_W-1:0] trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            s_cur    = in_s;
            rem_cur  = '0;
            root_cur = '0;
         end else begin
            s_cur    = s_ff[j-1];
            rem_cur  = rem_ff[j-1];
            root_cur = root_ff[j-1];
         end
         rem_sh = {rem_cur[SREM_W-3:0], s_cur[2*(SQRT_STAGES-1-j)+1 -: 2]};
         trial  = {1'b0, root_cur, 2'b01};
         if (rem_sh >= trial) begin
            rem_in[j]  = rem_sh - trial;
            root_in[j] = {root_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = rem_sh;
            root_in[j] = {root_cur[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQRT_STAGES; j++) vld_ff[j] <= 1'b0;
      end else begin
         for (int j = 0; j < SQRT_STAGES; j++) vld_ff[j] <= (j == 0) ? in_vld : vld_ff[j-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
         s_ff[j]    <= (j == 0) ? in_s : s_ff[j-1];
         tag_ff[j]  <= (j == 0) ? in_tag : tag_ff[j-1];
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
      end
   end

   assign out_vld  = vld_ff[SQRT_STAGES-1];
   assign out_root = root_ff[SQRT_STAGES-1];
   assign out_tag  = tag_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== design/eucm_div_pipe.sv =====
`default_nettype none
module eucm_div_pipe import eucm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire div_tag_type        in_tag,
   output logic                    out_vld,
   output logic [DIV_STAGES-1:0]   out_quo,
   output div_tag_type             out_tag
);

   logic                  vld_ff [DIV_STAGES];
   logic [NUM_W-1:0]      num_ff [DIV_STAGES];
   logic [DEN_W-1:0]      den_ff [DIV_STAGES];
   logic [REM_W-1:0]      rem_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] quo_ff [DIV_STAGES];
   div_tag_type           tag_ff [DIV_STAGES];

   logic [REM_W-1:0]      rem_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] quo_in [DIV_STAGES];

   // one quotient bit per stage; the top bits seed the remainder
   always_comb begin
      logic [NUM_W-1:0]      num_cur;
      logic [DEN_W-1:0]      den_cur;
      logic [REM_W-1:0]      rem_cur;
      logic [DIV_STAGES-1:0] quo_cur;
      logic [REM_W-1:0]      rem_sh;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            num_cur = in_num;
            den_cur = in_den;
            rem_cur = REM_W'(in_num[NUM_W-1:DIV_STAGES]);
            quo_cur = '0;
         end else begin
            num_cur = num_ff[j-1];
            den_cur = den_ff[j-1];
            rem_cur = rem_ff[j-1];
            quo_cur = quo_ff[j-1];
         end
         rem_sh = {rem_cur[REM_W-2:0], num_cur[DIV_STAGES-1-j]};
         if (rem_sh >= {1'b0, den_cur}) begin
            rem_in[j] = rem_sh - {1'b0, den_cur};
            quo_in[j] = {quo_cur[DIV_STAGES-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_sh;
            quo_in[j] = {quo_cur[DIV_STAGES-2:0], 1'b0};
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++) vld_ff[j] <= 1'b0;
      end else begin
         for (int j = 0; j < DIV_STAGES; j++) vld_ff[j] <= (j == 0) ? in_vld : vld_ff[j-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         num_ff[j] <= (j == 0) ? in_num : num_ff[j-1];
         den_ff[j] <= (j == 0) ? in_den : den_ff[j-1];
         tag_ff[j] <= (j == 0) ? in_tag : tag_ff[j-1];
         rem_ff[j] <= rem_in[j];
         quo_ff[j] <= quo_in[j];
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   assign out_quo = quo_ff[DIV_STAGES-1];
   assign out_tag = tag_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/eucm_project_ray_top.sv =====
`default_nettype none
// Extended unified camera model projection: one ray in, one pixel out.
// Input: a ray beat (req_ray_x/y/z, signed Q1.14) is taken at a clock edge
// with start high; busy stays low, so a new ray may enter every cycle.
// Output: rsp_strobe is high for one cycle with rsp_pixel_u/v (signed
// Q19.4, saturated) and rsp_proj_valid; an invalid ray gives zero pixels.
// The rate is one ray per cycle. The pipeline is made up of the square
// root pipe (one root bit per stage, 26 stages) and the two divider
// pipes (one quotient bit per stage, 29 stages), plus eight arithmetic
// stages: 63 register stages in all.
// The receiver cannot stall; every result is shown exactly once.
// Configuration goes through the APB port (registers at 4*index:
// focal_u, focal_v, center_u, center_v, shape_alpha, shape_beta) and must
// only be written while no ray is in flight.
// Synchronous reset empties the pipeline and restores register defaults;
// there is no clearing pass.
module eucm_project_ray_top import eucm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_ray_x,
   input  wire logic signed [15:0] req_ray_y,
   input  wire logic signed [15:0] req_ray_z,
   output logic                    rsp_strobe,
   output logic signed [23:0]      rsp_pixel_u,
   output logic signed [23:0]      rsp_pixel_v,
   output logic                    rsp_proj_valid,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // configuration registers
   logic [19:0] focal_u_ff, focal_v_ff, center_u_ff, center_v_ff, beta_ff;
   logic [15:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_u_ff  <= 20'd128000;
         focal_v_ff  <= 20'd128000;
         center_u_ff <= 20'd0;
         center_v_ff <= 20'd0;
         alpha_ff    <= 16'd32768;
         beta_ff     <= 20'd65536;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_FOCAL_U:     focal_u_ff  <= pwdata[19:0];
            REG_FOCAL_V:     focal_v_ff  <= pwdata[19:0];
            REG_CENTER_U:    center_u_ff <= pwdata[19:0];
            REG_CENTER_V:    center_v_ff <= pwdata[19:0];
            REG_SHAPE_ALPHA: alpha_ff    <= pwdata[15:0];
            REG_SHAPE_BETA:  beta_ff     <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (paddr[4:2])
         REG_FOCAL_U:     prdata = 32'(focal_u_ff);
         REG_FOCAL_V:     prdata = 32'(focal_v_ff);
         REG_CENTER_U:    prdata = 32'(center_u_ff);
         REG_CENTER_V:    prdata = 32'(center_v_ff);
         REG_SHAPE_ALPHA: prdata = 32'(alpha_ff);
         REG_SHAPE_BETA:  prdata = 32'(beta_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign busy   = 1'b0;

   // shared alpha terms
   logic [16:0]        gamma;
   logic signed [17:0] gamma_s;
   logic signed [16:0] alpha_s;
   assign gamma   = 17'h10000 - {1'b0, alpha_ff};
   assign gamma_s = $signed({1'b0, gamma});
   assign alpha_s = $signed({1'b0, alpha_ff});

   // stage a: input beat
   logic    a_vld_ff;
   ray_type a_ray_ff;

   // stage b: squares
   logic        b_vld_ff;
   ray_type     b_ray_ff;
   logic [30:0] b_xx_ff, b_yy_ff, b_zz_ff;
   logic signed [31:0] xx_in, yy_in, zz_in;

   // stage c: beta scaling
   logic           c_vld_ff;
   ray_type        c_ray_ff;
   logic [S_W-1:0] c_bm_ff, c_zs_ff;
   logic [31:0]    r2_in;

   // stage d: radicand
   logic           d_vld_ff;
   ray_type        d_ray_ff;
   logic [S_W-1:0] d_s_ff;

   always_comb begin
      xx_in = a_ray_ff.x * a_ray_ff.x;
      yy_in = a_ray_ff.y * a_ray_ff.y;
      zz_in = a_ray_ff.z * a_ray_ff.z;
      r2_in = 32'(b_xx_ff) + 32'(b_yy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ray_ff <= '{x: req_ray_x, y: req_ray_y, z: req_ray_z};
      b_ray_ff <= a_ray_ff;
      b_xx_ff  <= xx_in[30:0];
      b_yy_ff  <= yy_in[30:0];
      b_zz_ff  <= zz_in[30:0];
      c_ray_ff <= b_ray_ff;
      c_bm_ff  <= S_W'(beta_ff) * S_W'(r2_in);
      c_zs_ff  <= S_W'(b_zz_ff) << 16;
      d_ray_ff <= c_ray_ff;
      d_s_ff   <= c_bm_ff + c_zs_ff;
   end

   // rho = floor(sqrt(s))
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   ray_type           sq_ray;

   eucm_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (d_vld_ff),
      .in_s     (d_s_ff),
      .in_tag   (d_ray_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_tag  (sq_ray)
   );

   // stage e: products for the validity test, the norm and the focal terms
   logic               e_vld_ff;
   logic [41:0]        e_p1_ff;
   logic [42:0]        e_p2_ff;
   logic signed [41:0] e_p3_ff;
   logic signed [40:0] e_p4_ff;
   logic [34:0]        e_fx_ff, e_fy_ff;
   logic               e_nx_ff, e_ny_ff;
   logic signed [23:0] zq;
   logic [15:0]        mag_x, mag_y;

   always_comb begin
      zq    = {sq_ray.z, 8'b0};
      mag_x = sq_ray.x[15] ? 16'(-sq_ray.x) : sq_ray.x;
      mag_y = sq_ray.y[15] ? 16'(-sq_ray.y) : sq_ray.y;
   end

   // stage f: validity and norm
   logic               f_vld_ff, f_ok_ff;
   logic [DEN_W-1:0]   f_den_ff;
   logic [34:0]        f_fx_ff, f_fy_ff;
   logic               f_nx_ff, f_ny_ff;
   logic signed [44:0] norm_in, alt_in;
   logic               ok_in;

   always_comb begin
      norm_in = 45'($signed({1'b0, e_p1_ff})) + 45'(e_p3_ff);
      alt_in  = 45'($signed({1'b0, e_p2_ff})) + 45'(e_p4_ff);
      ok_in   = e_vld_ff && !norm_in[44] && (norm_in != '0) &&
                ((alpha_ff <= 16'd32768) || (!alt_in[44] && (alt_in != '0)));
   end

   // stage g: rounded numerators and range check
   logic             g_vld_ff;
   logic [NUM_W-1:0] g_nu_ff, g_nv_ff;
   logic [DEN_W-1:0] g_den_ff;
   div_tag_type      g_tu_ff, g_tv_ff;
   logic [NUM_W-1:0] nu_in, nv_in;

   always_comb begin
      nu_in = NUM_W'({f_fx_ff, 24'b0}) + NUM_W'(f_den_ff >> 1);
      nv_in = NUM_W'({f_fy_ff, 24'b0}) + NUM_W'(f_den_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= sq_vld;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_p1_ff  <= 42'(alpha_ff) * 42'(sq_root);
      e_p2_ff  <= 43'(gamma) * 43'(sq_root);
      e_p3_ff  <= gamma_s * zq;
      e_p4_ff  <= alpha_s * zq;
      e_fx_ff  <= 35'(focal_u_ff) * 35'(mag_x);
      e_fy_ff  <= 35'(focal_v_ff) * 35'(mag_y);
      e_nx_ff  <= sq_ray.x[15];
      e_ny_ff  <= sq_ray.y[15];
      f_ok_ff  <= ok_in;
      f_den_ff <= ok_in ? norm_in[DEN_W-1:0] : DEN_W'(1);
      f_fx_ff  <= e_fx_ff;
      f_fy_ff  <= e_fy_ff;
      f_nx_ff  <= e_nx_ff;
      f_ny_ff  <= e_ny_ff;
      g_nu_ff  <= nu_in;
      g_nv_ff  <= nv_in;
      g_den_ff <= f_den_ff;
      g_tu_ff  <= '{neg: f_nx_ff, ovf: DEN_W'(nu_in[NUM_W-1:DIV_STAGES]) >= f_den_ff,
                    ok: f_ok_ff};
      g_tv_ff  <= '{neg: f_ny_ff, ovf: DEN_W'(nv_in[NUM_W-1:DIV_STAGES]) >= f_den_ff,
                    ok: f_ok_ff};
   end

   // quotients, one divider per axis
   logic                  du_vld, dv_vld;
   logic [DIV_STAGES-1:0] du_quo, dv_quo;
   div_tag_type           du_tag, dv_tag;

   eucm_div_pipe u_div_u (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (g_vld_ff),
      .in_num  (g_nu_ff),
      .in_den  (g_den_ff),
      .in_tag  (g_tu_ff),
      .out_vld (du_vld),
      .out_quo (du_quo),
      .out_tag (du_tag)
   );

   eucm_div_pipe u_div_v (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (g_vld_ff),
      .in_num  (g_nv_ff),
      .in_den  (g_den_ff),
      .in_tag  (g_tv_ff),
      .out_vld (dv_vld),
      .out_quo (dv_quo),
      .out_tag (dv_tag)
   );

   // sign, center offset, round to Q.4 and saturate
   function automatic logic signed [23:0] finish_axis(
      input logic [DIV_STAGES-1:0] quo,
      input div_tag_type           tag,
      input logic [19:0]           ctr
   );
      logic [DIV_STAGES:0] qmag;
      logic signed [31:0]  sq;
      logic signed [31:0]  t;
      logic signed [31:0]  r;
      qmag = tag.ovf ? {1'b1, {DIV_STAGES{1'b0}}} : {1'b0, quo};
      sq   = tag.neg ? -$signed(32'(qmag)) : $signed(32'(qmag));
      t    = sq + $signed(32'(ctr)) + 32'sd8;
      r    = t >>> 4;
      if (!tag.ok)         finish_axis = '0;
      else if (r > OUT_MAX) finish_axis = OUT_MAX[23:0];
      else if (r < OUT_MIN) finish_axis = OUT_MIN[23:0];
      else                  finish_axis = r[23:0];
   endfunction

   // result register
   logic               out_vld_ff;
   logic signed [23:0] out_u_ff, out_v_ff;
   logic               out_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= du_vld && dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      out_u_ff  <= finish_axis(du_quo, du_tag, center_u_ff);
      out_v_ff  <= finish_axis(dv_quo, dv_tag, center_v_ff);
      out_ok_ff <= du_tag.ok;
   end

   assign rsp_strobe     = out_vld_ff;
   assign rsp_pixel_u    = out_u_ff;
   assign rsp_pixel_v    = out_v_ff;
   assign rsp_proj_valid = out_ok_ff;

endmodule
`default_nettype wire

// ===== bench/tb_eucm_project_ray_top.sv =====
`default_nettype none
module tb_eucm_project_ray_top import eucm_pkg::*; ();

   localparam int LATENCY   = 64;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 2000;

   // pixel result held for comparison
   typedef struct packed {
      logic signed [23:0] pu;
      logic signed [23:0] pv;
      logic               ok;
   } pixel_type;

   // directed stimulus row; has_exp marks rows with a typed-in answer
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      bit                 has_exp;
      pixel_type          exp;
   } ray_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_ray_x = '0, req_ray_y = '0, req_ray_z = '0;
   logic rsp_strobe;
   logic signed [23:0] rsp_pixel_u, rsp_pixel_v;
   logic rsp_proj_valid;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   eucm_project_ray_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ray_x(req_ray_x), .req_ray_y(req_ray_y), .req_ray_z(req_ray_z),
      .rsp_strobe(rsp_strobe), .rsp_pixel_u(rsp_pixel_u),
      .rsp_pixel_v(rsp_pixel_v), .rsp_proj_valid(rsp_proj_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // camera setting mirrored for the projection predictor
   logic [19:0] cam_fu, cam_fv, cam_cu, cam_cv, cam_beta;
   logic [15:0] cam_alpha;

   pixel_type pixel_queue[$];
   int errors = 0;
   int n_rays = 0;
   int n_pixels = 0;
   int n_valid = 0;
   int n_settings = 0;
   int idle_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d (pixel %0d)", what, got, want, n_pixels);
   endtask

   function automatic longint unsigned root_floor(input longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // one axis: f*c/norm + center, q.4 with saturation
   function automatic logic signed [23:0] axis_pixel(input longint unsigned f,
         input longint c, input longint norm, input longint unsigned ctr);
      longint unsigned mag, num, qm;
      longint sum, t, r;
      mag = (c < 0) ? -c : c;
      num = (f * mag) << 24;
      qm = (num + longint'(norm) / 2) / longint'(norm);
      sum = ((c < 0) ? -longint'(qm) : longint'(qm)) + longint'(ctr);
      t = sum + 8;
      if (t >= 0) r = t >>> 4;
      else r = -((-t + 15) >>> 4);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
   endfunction

   function automatic pixel_type project_ray(input logic signed [15:0] x,
         input logic signed [15:0] y, input logic signed [15:0] z);
      pixel_type p;
      longint xi, yi, zi, rho, zq, a, ga, norm;
      longint unsigned r2, s;
      bit ok;
      xi = x; yi = y; zi = z;
      r2 = xi * xi + yi * yi;
      s = longint'(cam_beta) * r2 + ((zi * zi) << 16);
      rho = root_floor(s);
      zq = zi * 256;
      a = cam_alpha;
      ga = 65536 - a;
      if (cam_alpha <= 16'd32768) ok = !(zq * ga <= -(a * rho));
      else ok = !(zq * a <= -(ga * rho));
      norm = a * rho + ga * zq;
      if (norm <= 0) ok = 0;
      p = '0;
      if (ok) begin
         p.pu = axis_pixel(cam_fu, xi, norm, cam_cu);
         p.pv = axis_pixel(cam_fv, yi, norm, cam_cv);
         p.ok = 1'b1;
      end
      return p;
   endfunction

   // result side: compare every strobe with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected pixel", 1, 0);
         end else begin
            pixel_type want;
            want = pixel_queue.pop_front();
            if (rsp_pixel_u !== want.pu) report_mismatch("pixel_u", rsp_pixel_u, want.pu);
            if (rsp_pixel_v !== want.pv) report_mismatch("pixel_v", rsp_pixel_v, want.pv);
            if (rsp_proj_valid !== want.ok)
               report_mismatch("proj_valid", rsp_proj_valid, want.ok);
            if (want.ok) n_valid++;
         end
         n_pixels++;
      end
   end

   // watchdog on cycles with no ray accepted, no pixel and no register access
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("FAIL eucm_project_ray_top");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_FOCAL_U:     cam_fu = val[19:0];
         REG_FOCAL_V:     cam_fv = val[19:0];
         REG_CENTER_U:    cam_cu = val[19:0];
         REG_CENTER_V:    cam_cv = val[19:0];
         REG_SHAPE_ALPHA: cam_alpha = val[15:0];
         REG_SHAPE_BETA:  cam_beta = val[19:0];
         default: ;
      endcase
   endtask

   task automatic load_camera(input logic [19:0] fu, input logic [19:0] fv,
         input logic [19:0] cu, input logic [19:0] cv, input logic [15:0] al,
         input logic [19:0] be);
      csr_write(REG_FOCAL_U, 32'(fu));
      csr_write(REG_FOCAL_V, 32'(fv));
      csr_write(REG_CENTER_U, 32'(cu));
      csr_write(REG_CENTER_V, 32'(cv));
      csr_write(REG_SHAPE_ALPHA, 32'(al));
      csr_write(REG_SHAPE_BETA, 32'(be));
      n_settings++;
   endtask

   // hold the request line at the next edge, one beat
   task automatic send_ray(input logic signed [15:0] x, input logic signed [15:0] y,
         input logic signed [15:0] z, input bit keep_high);
      start <= 1'b1;
      req_ray_x <= x; req_ray_y <= y; req_ray_z <= z;
      do @(posedge clock); while (busy);
      n_rays++;
      if (!keep_high) start <= 1'b0;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic drain();
      int lim;
      lim = 0;
      while (pixel_queue.size() != 0 && lim < 20 * LATENCY) begin
         @(posedge clock);
         lim++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random ray: mostly forward, some backward and extreme
   task automatic random_ray(output logic signed [15:0] x, output logic signed [15:0] y,
         output logic signed [15:0] z);
      int k;
      k = $urandom_range(0, 9);
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (k < 6) z = 16'($urandom_range(0, 32767));
      else if (k == 6) begin
         x = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
         y = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
      end else if (k == 7) begin
         x = 16'($urandom_range(0, 63) - 32); y = 16'($urandom_range(0, 63) - 32);
      end
   endtask

   task automatic run_random(input int count);
      logic signed [15:0] x, y, z;
      int g;
      bit more;
      for (int i = 0; i < count; i++) begin
         random_ray(x, y, z);
         pixel_queue.push_back(project_ray(x, y, z));
         g = gap_len();
         more = (g == 0) && (i != count - 1);
         send_ray(x, y, z, more);
         repeat (g) @(posedge clock);
      end
      start <= 1'b0;
   endtask

   ray_row_type rows[$];

   function automatic ray_row_type mk(input int x, input int y, input int z,
         input bit he, input int eu, input int ev, input bit eo);
      ray_row_type r;
      r.x = 16'(x); r.y = 16'(y); r.z = 16'(z); r.has_exp = he;
      r.exp.pu = 24'(eu); r.exp.pv = 24'(ev); r.exp.ok = eo;
      return r;
   endfunction

   initial begin
      pixel_type p;
      cam_fu = 20'd128000; cam_fv = 20'd128000; cam_cu = 20'd0; cam_cv = 20'd0;
      cam_alpha = 16'd32768; cam_beta = 20'd65536;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset camera
      rows.push_back(mk(0, 0, 16384, 1, 0, 0, 1));        // straight ahead
      rows.push_back(mk(0, 0, 0, 1, 0, 0, 0));            // zero ray
      rows.push_back(mk(0, 0, -16384, 1, 0, 0, 0));       // straight behind
      rows.push_back(mk(0, 0, -32768, 1, 0, 0, 0));
      rows.push_back(mk(32767, 32767, 32767, 0, 0, 0, 0));
      rows.push_back(mk(-32768, -32768, 32767, 0, 0, 0, 0));
      rows.push_back(mk(-32768, 32767, -32768, 0, 0, 0, 0));
      rows.push_back(mk(32767, 0, 0, 0, 0, 0, 0));        // sideways
      rows.push_back(mk(-32768, 0, 1, 0, 0, 0, 0));
      rows.push_back(mk(1, -1, 1, 0, 0, 0, 0));
      rows.push_back(mk(16384, -16384, -100, 0, 0, 0, 0)); // near the validity edge
      rows.push_back(mk(100, 200, 32767, 0, 0, 0, 0));
      foreach (rows[i]) begin
         p = project_ray(rows[i].x, rows[i].y, rows[i].z);
         if (rows[i].has_exp && p !== rows[i].exp)
            report_mismatch("table row", i, -1);
         pixel_queue.push_back(rows[i].has_exp ? rows[i].exp : p);
         send_ray(rows[i].x, rows[i].y, rows[i].z, i != rows.size() - 1);
      end
      drain();

      // zero alpha, max beta, extreme focal and center, then the table again
      load_camera(20'd1, 20'hFFFFF, 20'hFFFFF, 20'd0, 16'd0, 20'hFFFFF);
      foreach (rows[i]) begin
         pixel_queue.push_back(project_ray(rows[i].x, rows[i].y, rows[i].z));
         send_ray(rows[i].x, rows[i].y, rows[i].z, i != rows.size() - 1);
      end
      drain();
      load_camera(20'hFFFFF, 20'd1, 20'd0, 20'hFFFFF, 16'hFFFF, 20'd1);
      run_random(100);
      drain();

      // random settings across the rest of the run
      for (int ph = 0; ph < 8; ph++) begin
         load_camera(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 20'hFFFFF)),
            20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
            (ph == 0) ? 16'd32768 : (ph == 1) ? 16'd32769 : 16'($urandom),
            20'($urandom_range(1, 20'hFFFFF)));
         run_random(N_RANDOM / 8);
         drain();
      end

      if (pixel_queue.size() != 0) report_mismatch("pixels missing", 0, pixel_queue.size());
      $display("rays sent %0d, pixels checked %0d (%0d valid)", n_rays, n_pixels, n_valid);
      $display("camera settings loaded %0d", n_settings);
      if (errors == 0) begin
         $display("PASS eucm_project_ray_top");
      end else begin
         $display("FAIL eucm_project_ray_top");
      end
      $finish;
   end
endmodule
`default_nettype wire
